FILE: hw/rtl/bmsu_pkg.sv
package bmsu_pkg;

    typedef enum logic [1:0] {
        FUNC_DIV    = 2'd0,
        FUNC_DIVARM = 2'd1,
        FUNC_SQRT   = 2'd2,
        FUNC_ATAN   = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] r0_in;
        logic [31:0] r1_in;
    } req_t;

    typedef struct packed {
        logic [31:0] r0_out;
        logic [31:0] r1_out;
        logic [31:0] r3_out;
        logic [2:0]  write_mask;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_ATAN,
        ST_DONE
    } state_t;

    localparam logic [2:0] MASK_NONE = 3'd0;
    localparam logic [2:0] MASK_R0   = 3'd1;
    localparam logic [2:0] MASK_ALL  = 3'd7;

    localparam logic signed [47:0] ATAN_ONE = 48'sd8192;
    localparam logic signed [47:0] ATAN_C3  = 48'sd3632;
    localparam logic signed [47:0] ATAN_C5  = 48'sd118;
    localparam int ATAN_FRAC      = 14;
    localparam int ATAN_OUT_SHIFT = 16;

endpackage

FILE: hw/rtl/bios_math_service_unit.sv
// Math service unit. A request transfers on a rising edge where start is high and busy is
// low. Busy then stays high through the cycle in which done is high, and the result is on
// rsp in that cycle and stays there until the next result. The receiver cannot stall, so it
// must take the result in that cycle. The operations:
// - Div and DivArm run 32 restoring steps of the shared subtractor, then a sign fix-up.
// - A zero divisor writes nothing and is answered straight from idle.
// - Sqrt runs 16 steps of the same subtractor.
// - ArcTan runs five products through one shared 32x32 multiplier, one per cycle, and a
//   final shift.
// The next request can transfer on the edge after the result cycle.
module bios_math_service_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  bmsu_pkg::req_t req,
    output logic           busy,
    output logic           done,
    output bmsu_pkg::rsp_t rsp
);

    bmsu_pkg::state_t state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [1:0]  func_reg, func_next;
    logic [31:0] acc_reg, acc_next;      // remainder / radicand
    logic [31:0] quo_reg, quo_next;      // quotient / root
    logic [31:0] den_reg, den_next;      // |divisor| / sqrt bit
    logic [31:0] num_reg, num_next;      // raw numerator
    logic        nneg_reg, nneg_next, dneg_reg, dneg_next;
    logic signed [47:0] x_reg, x_next, a_reg, a_next, t_reg, t_next;
    bmsu_pkg::rsp_t rsp_reg, rsp_next;
    logic done_reg, done_next;

    // Shared subtractor.
    logic [32:0] sub_a, sub_b, sub_d;
    // Shared multiplier.
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic signed [47:0] mul_s;

    assign sub_d = sub_a - sub_b;
    assign mul_p = mul_a * mul_b;
    assign mul_s = 48'(mul_p >>> bmsu_pkg::ATAN_FRAC);

    logic [31:0] div_num, div_den;
    logic [31:0] quo_fix, rem_fix;
    logic [32:0] shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmsu_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        func_reg <= func_next;
        acc_reg  <= acc_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        nneg_reg <= nneg_next;
        dneg_reg <= dneg_next;
        x_reg    <= x_next;
        a_reg    <= a_next;
        t_reg    <= t_next;
        rsp_reg  <= rsp_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        func_next  = func_reg;
        acc_next   = acc_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        num_next   = num_reg;
        nneg_next  = nneg_reg;
        dneg_next  = dneg_reg;
        x_next     = x_reg;
        a_next     = a_reg;
        t_next     = t_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        sub_a      = 33'd0;
        sub_b      = 33'd0;
        mul_a      = 32'sd0;
        mul_b      = 32'sd0;
        shifted    = {acc_reg, quo_reg[31]};
        quo_fix    = (nneg_reg != dneg_reg) ? 32'd0 - quo_reg : quo_reg;
        rem_fix    = nneg_reg ? 32'd0 - acc_reg : acc_reg;
        div_num    = (req.func == bmsu_pkg::FUNC_DIV) ? req.r0_in : req.r1_in;
        div_den    = (req.func == bmsu_pkg::FUNC_DIV) ? req.r1_in : req.r0_in;

        case (state_reg)
            bmsu_pkg::ST_IDLE:
            begin
                // The result cycle is spent in idle with busy still high.
                if (start && !done_reg)
                begin
                    func_next = req.func;
                    cnt_next  = 6'd0;
                    case (bmsu_pkg::func_t'(req.func))
                        bmsu_pkg::FUNC_DIV, bmsu_pkg::FUNC_DIVARM:
                        begin
                            nneg_next = div_num[31];
                            dneg_next = div_den[31];
                            num_next  = div_num;
                            // quo_reg holds |num| and shifts into acc.
                            quo_next  = div_num[31] ? 32'd0 - div_num : div_num;
                            den_next  = div_den[31] ? 32'd0 - div_den : div_den;
                            acc_next  = 32'd0;
                            if (div_den == 32'd0)
                            begin
                                rsp_next   = '0;
                                done_next  = 1'b1;
                            end
                            else
                                state_next = bmsu_pkg::ST_DIV;
                        end
                        bmsu_pkg::FUNC_SQRT:
                        begin
                            acc_next   = req.r0_in;
                            quo_next   = 32'd0;
                            den_next   = 32'h4000_0000;
                            state_next = bmsu_pkg::ST_SQRT;
                        end
                        default:
                        begin
                            x_next     = 48'(signed'(req.r0_in[31:16]));
                            state_next = bmsu_pkg::ST_ATAN;
                        end
                    endcase
                end
            end

            bmsu_pkg::ST_DIV:
            begin
                // One restoring step: shift in the next numerator bit, try to subtract.
                sub_a = shifted;
                sub_b = {1'b0, den_reg};
                cnt_next = cnt_reg + 6'd1;
                if (!sub_d[32])
                begin
                    acc_next = sub_d[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    acc_next = shifted[31:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                if (cnt_reg == 6'd32)
                begin
                    acc_next  = acc_reg;
                    quo_next  = quo_reg;
                    rsp_next.r0_out = quo_fix;
                    rsp_next.r1_out = rem_fix;
                    rsp_next.r3_out = (func_reg == bmsu_pkg::FUNC_DIV) ? den_reg : num_reg;
                    rsp_next.write_mask = bmsu_pkg::MASK_ALL;
                    done_next  = 1'b1;
                    state_next = bmsu_pkg::ST_IDLE;
                end
            end

            bmsu_pkg::ST_SQRT:
            begin
                // Leading bit skips are equivalent to failed steps here.
                sub_a = {1'b0, acc_reg};
                sub_b = {1'b0, quo_reg + den_reg};
                if (!sub_d[32])
                begin
                    acc_next = sub_d[31:0];
                    quo_next = (quo_reg >> 1) + den_reg;
                end
                else
                    quo_next = quo_reg >> 1;
                den_next = den_reg >> 2;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd15)
                    state_next = bmsu_pkg::ST_DONE;
            end

            bmsu_pkg::ST_ATAN:
            begin
                cnt_next = cnt_reg + 6'd1;
                case (cnt_reg)
                    6'd0:
                    begin
                        mul_a  = 32'(x_reg);
                        mul_b  = 32'(x_reg);
                        a_next = mul_s;                       // a
                    end
                    6'd1:
                    begin
                        mul_a  = 32'(a_reg);
                        mul_b  = 32'(bmsu_pkg::ATAN_C5);
                        t_next = 48'(mul_p);                  // a*C5, unscaled
                    end
                    6'd2:
                    begin
                        mul_a  = 32'(a_reg);
                        mul_b  = 32'(bmsu_pkg::ATAN_C3 - t_reg);
                        t_next = mul_s;                       // t
                    end
                    6'd3:
                    begin
                        mul_a  = 32'(a_reg);
                        mul_b  = 32'(bmsu_pkg::ATAN_ONE - t_reg);
                        t_next = mul_s;                       // a2
                    end
                    6'd4:
                    begin
                        mul_a  = 32'(x_reg);
                        mul_b  = 32'(t_reg);
                        t_next = mul_s;                       // x*a2 >> 14
                    end
                    default:
                    begin
                        a_next     = ((x_reg <<< 13) - t_reg) >>> bmsu_pkg::ATAN_OUT_SHIFT;
                        quo_next   = a_next[31:0];
                        state_next = bmsu_pkg::ST_DONE;
                    end
                endcase
            end

            bmsu_pkg::ST_DONE:
            begin
                rsp_next.r0_out     = quo_reg;
                rsp_next.r1_out     = 32'd0;
                rsp_next.r3_out     = 32'd0;
                rsp_next.write_mask = bmsu_pkg::MASK_R0;
                done_next  = 1'b1;
                state_next = bmsu_pkg::ST_IDLE;
            end

            default:
                state_next = bmsu_pkg::ST_IDLE;
        endcase
    end

    assign busy = (state_reg != bmsu_pkg::ST_IDLE) || done_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for two cycles");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != bmsu_pkg::ST_IDLE) |-> busy)
        else $error("busy low while working");
    a_mask: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.write_mask == bmsu_pkg::MASK_NONE || rsp.write_mask == bmsu_pkg::MASK_R0
                  || rsp.write_mask == bmsu_pkg::MASK_ALL))
        else $error("illegal write mask");

endmodule

FILE: test/tb_bios_math_service_unit.sv
`timescale 1ns / 1ps

module tb_bios_math_service_unit;

    localparam int LONGEST_OP = 34;
    localparam int RANDOM_ITEMS = 950;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic start;
    bmsu_pkg::req_t req;
    logic busy;
    logic done;
    bmsu_pkg::rsp_t rsp;

    bmsu_pkg::rsp_t result_queue[$];
    int fail_count;
    longint cycle_count;

    typedef struct {
        bmsu_pkg::func_t fn;
        logic [31:0]     r0;
        logic [31:0]     r1;
        logic            has_fixed;
        bmsu_pkg::rsp_t  fixed;
    } stim_row_t;

    stim_row_t stim_table[$];

    bios_math_service_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Arithmetic shift right on signed values floors, which the polynomial needs.
    function automatic logic [31:0] atan_poly(logic [31:0] arg);
        longint x;
        longint a;
        longint t;
        longint a2;
        longint res;
        x = longint'($signed(arg[31:16]));
        a = (x * x) >>> bmsu_pkg::ATAN_FRAC;
        t = (a * (3632 - a * 118)) >>> bmsu_pkg::ATAN_FRAC;
        a2 = (a * (8192 - t)) >>> bmsu_pkg::ATAN_FRAC;
        res = (8192 * x - ((x * a2) >>> bmsu_pkg::ATAN_FRAC)) >>> bmsu_pkg::ATAN_OUT_SHIFT;
        return res[31:0];
    endfunction

    function automatic logic [31:0] int_sqrt(logic [31:0] v);
        logic [31:0] root;
        logic [31:0] bitpos;
        root = 32'd0;
        bitpos = 32'h4000_0000;
        while (bitpos > v)
            bitpos = bitpos >> 2;
        while (bitpos != 32'd0)
        begin
            if (v >= root + bitpos)
            begin
                v = v - (root + bitpos);
                root = (root >> 1) + bitpos;
            end
            else
            begin
                root = root >> 1;
            end
            bitpos = bitpos >> 2;
        end
        return root;
    endfunction

    function automatic bmsu_pkg::rsp_t signed_divide(logic [31:0] num, logic [31:0] den);
        bmsu_pkg::rsp_t r;
        logic [31:0] un;
        logic [31:0] ud;
        logic [31:0] q;
        logic [31:0] rm;
        un = num[31] ? -num : num;
        ud = den[31] ? -den : den;
        q = un / ud;
        rm = un % ud;
        r.r0_out = (num[31] != den[31]) ? -q : q;
        r.r1_out = num[31] ? -rm : rm;
        r.r3_out = ud;
        r.write_mask = bmsu_pkg::MASK_ALL;
        return r;
    endfunction

    function automatic bmsu_pkg::rsp_t service_result(bmsu_pkg::req_t q);
        bmsu_pkg::rsp_t r;
        r = '0;
        case (bmsu_pkg::func_t'(q.func))
            bmsu_pkg::FUNC_DIV:
                if (q.r1_in != 32'd0)
                    r = signed_divide(q.r0_in, q.r1_in);
            bmsu_pkg::FUNC_DIVARM:
                if (q.r0_in != 32'd0)
                begin
                    r = signed_divide(q.r1_in, q.r0_in);
                    r.r3_out = q.r1_in;
                end
            bmsu_pkg::FUNC_SQRT:
            begin
                r.r0_out = int_sqrt(q.r0_in);
                r.write_mask = bmsu_pkg::MASK_R0;
            end
            default:
            begin
                r.r0_out = atan_poly(q.r0_in);
                r.write_mask = bmsu_pkg::MASK_R0;
            end
        endcase
        return r;
    endfunction

    function automatic bmsu_pkg::rsp_t fixed_rsp(logic [31:0] o0, logic [31:0] o1,
                                                 logic [31:0] o3, logic [2:0] m);
        bmsu_pkg::rsp_t r;
        r.r0_out = o0;
        r.r1_out = o1;
        r.r3_out = o3;
        r.write_mask = m;
        return r;
    endfunction

    function automatic stim_row_t make_row(bmsu_pkg::func_t fn, logic [31:0] r0,
                                           logic [31:0] r1, logic has_fixed,
                                           bmsu_pkg::rsp_t fixed);
        stim_row_t s;
        s.fn = fn;
        s.r0 = r0;
        s.r1 = r1;
        s.has_fixed = has_fixed;
        s.fixed = fixed;
        return s;
    endfunction

    // Drives one transfer and queues the expected result. Busy read right after an edge
    // still holds the value the block saw at that edge, so the loop ends on the accepting
    // edge. Start stays high afterwards; the caller lowers it before a gap.
    task automatic send_request(stim_row_t s);
        bmsu_pkg::req_t q;
        q.func = s.fn;
        q.r0_in = s.r0;
        q.r1_in = s.r1;
        req <= q;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        result_queue.push_back(s.has_fixed ? s.fixed : service_result(q));
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000 + $urandom_range(0, 3);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return 32'h8000_0000 + $urandom_range(0, 1);
            3: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (result_queue.size() == 0)
            begin
                $error("result with no request outstanding");
                fail_count++;
            end
            else
            begin
                bmsu_pkg::rsp_t e;
                e = result_queue.pop_front();
                if (rsp.r0_out !== e.r0_out)
                begin
                    $error("r0_out expected %h actual %h", e.r0_out, rsp.r0_out);
                    fail_count++;
                end
                if (rsp.r1_out !== e.r1_out)
                begin
                    $error("r1_out expected %h actual %h", e.r1_out, rsp.r1_out);
                    fail_count++;
                end
                if (rsp.r3_out !== e.r3_out)
                begin
                    $error("r3_out expected %h actual %h", e.r3_out, rsp.r3_out);
                    fail_count++;
                end
                if (rsp.write_mask !== e.write_mask)
                begin
                    $error("write_mask expected %h actual %h", e.write_mask, rsp.write_mask);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int burst;
        int gap;
        bmsu_pkg::rsp_t z;
        fail_count = 0;
        cycle_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        z = '0;

        stim_table.push_back(make_row(bmsu_pkg::FUNC_DIV, 32'd7, 32'd0, 1'b1,
                                      fixed_rsp(32'd0, 32'd0, 32'd0, bmsu_pkg::MASK_NONE)));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_DIVARM, 32'd0, 32'd9, 1'b1,
                                      fixed_rsp(32'd0, 32'd0, 32'd0, bmsu_pkg::MASK_NONE)));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
                                      fixed_rsp(32'h8000_0000, 32'd0, 32'd1,
                                                bmsu_pkg::MASK_ALL)));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_DIVARM, 32'hFFFF_FFFF, 32'h8000_0000,
                                      1'b1,
                                      fixed_rsp(32'h8000_0000, 32'd0, 32'h8000_0000,
                                                bmsu_pkg::MASK_ALL)));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_DIV, 32'd5, 32'h8000_0000, 1'b1,
                                      fixed_rsp(32'd0, 32'd5, 32'h8000_0000,
                                                bmsu_pkg::MASK_ALL)));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_DIV, -32'sd7, 32'd2, 1'b0, z));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_DIV, 32'd7, -32'sd2, 1'b0, z));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_DIV, -32'sd7, -32'sd2, 1'b0, z));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_DIV, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                      1'b0, z));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_DIVARM, 32'd3, 32'd100, 1'b0, z));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_DIVARM, 32'h7FFF_FFFF, 32'h8000_0000,
                                      1'b0, z));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_SQRT, 32'd0, 32'd0, 1'b1,
                                      fixed_rsp(32'd0, 32'd0, 32'd0, bmsu_pkg::MASK_R0)));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_SQRT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                      fixed_rsp(32'h0000_FFFF, 32'd0, 32'd0,
                                                bmsu_pkg::MASK_R0)));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_SQRT, 32'd1, 32'd0, 1'b0, z));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_SQRT, 32'h4000_0000, 32'd0, 1'b0, z));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_SQRT, 32'd99, 32'd0, 1'b0, z));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_ATAN, 32'd0, 32'd0, 1'b1,
                                      fixed_rsp(32'd0, 32'd0, 32'd0, bmsu_pkg::MASK_R0)));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_ATAN, 32'h7FFF_FFFF, 32'd0, 1'b0, z));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_ATAN, 32'h8000_0000, 32'd0, 1'b0, z));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_ATAN, 32'hFFFF_0000, 32'hFFFF_FFFF,
                                      1'b0, z));
        stim_table.push_back(make_row(bmsu_pkg::FUNC_ATAN, 32'h0001_FFFF, 32'd0, 1'b0, z));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
            send_request(stim_table[i]);

        burst = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                gap = $urandom_range(0, 40);
                if (gap != 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst--;
            send_request(make_row(bmsu_pkg::func_t'(2'($urandom_range(0, 3))), rand_word(),
                                  rand_word(), 1'b0, z));
        end
        start <= 1'b0;

        while (result_queue.size() != 0)
            @(posedge clk);
        repeat (LONGEST_OP + 6) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/bmsu_pkg.sv
hw/rtl/bios_math_service_unit.sv
test/tb_bios_math_service_unit.sv
